[sv/sliding_mode_rotor_observer_unit_macros.svh]
// assertion helpers used by the observer control module
`ifndef SLIDING_MODE_ROTOR_OBSERVER_UNIT_MACROS_SVH
`define SLIDING_MODE_ROTOR_OBSERVER_UNIT_MACROS_SVH

// same-cycle implication
`define SMRO_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SMRO_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/smro_pkg.sv]
package smro_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_DECAY    = 3'd0;
   localparam logic [2:0] CSR_VGAIN    = 3'd1;
   localparam logic [2:0] CSR_SLIDE    = 3'd2;
   localparam logic [2:0] CSR_SLIDEMAX = 3'd3;
   localparam logic [2:0] CSR_MINGAIN  = 3'd4;
   localparam logic [2:0] CSR_RPM      = 3'd5;

   localparam logic [30:0] SLIDE_MAX_RST = 31'd536870912;
   localparam logic signed [31:0] EST_HI = 32'sh3FFF_0000;
   localparam logic signed [31:0] EST_LO = 32'shC000_0000;
   localparam logic signed [16:0] ANG_SCALE = 17'sd5215;
   localparam logic signed [16:0] GAIN_COEF = 17'sd25736;
   localparam logic signed [15:0] OFS_POS = 16'sd13007;
   localparam logic signed [15:0] OFS_NEG = 16'sd19761;
   localparam logic signed [19:0] PI_Q16 = 20'sd205887;
   localparam int unsigned CORDIC_STEPS = 16;

   typedef struct packed {
      logic signed [31:0] volt_alpha;
      logic signed [31:0] volt_beta;
      logic signed [31:0] amp_alpha;
      logic signed [31:0] amp_beta;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] elec_position;
      logic signed [31:0] elec_speed_rpm;
      logic signed [31:0] emf_alpha;
      logic signed [31:0] emf_beta;
   } rsp_word_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_VG, ST_DEC, ST_EST, ST_SW, ST_SWC, ST_F1, ST_F1W, ST_F2, ST_F2W,
      ST_CINIT, ST_CROT, ST_ANG, ST_THW, ST_SPD, ST_SF, ST_SFW, ST_RPM, ST_RPMW, ST_GAIN
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_VG, OP_DEC, OP_EST, OP_SW, OP_SWC, OP_F1, OP_F1W, OP_F2,
      OP_F2W, OP_CINIT, OP_CROT, OP_ANG, OP_THW, OP_SPD, OP_SF, OP_SFW, OP_RPM,
      OP_RPMW, OP_GAIN
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       ax;
      logic [3:0] step;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   // arctangent of 2^-i in q16
   function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
      logic signed [19:0] r;
      unique case (i)
         4'd0:  r = 20'sd51472;
         4'd1:  r = 20'sd30385;
         4'd2:  r = 20'sd16055;
         4'd3:  r = 20'sd8150;
         4'd4:  r = 20'sd4091;
         4'd5:  r = 20'sd2047;
         4'd6:  r = 20'sd1024;
         4'd7:  r = 20'sd512;
         4'd8:  r = 20'sd256;
         4'd9:  r = 20'sd128;
         4'd10: r = 20'sd64;
         4'd11: r = 20'sd32;
         4'd12: r = 20'sd16;
         4'd13: r = 20'sd8;
         4'd14: r = 20'sd4;
         default: r = 20'sd2;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[sv/smro_ram.sv]
module smro_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[sv/smro_ctrl.sv]
module smro_ctrl
   import smro_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type stat,
   output cmd_type    cmd
);

`include "sliding_mode_rotor_observer_unit_macros.svh"

   state_type  state_ff, state_in;
   logic       ax_ff, ax_in;
   logic [3:0] cnt_ff, cnt_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ax_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ax_ff    <= ax_in;
         cnt_ff   <= cnt_in;
      end
   end

   // sequence: alpha chain, beta chain, cordic, angle, speed, gain and result
   always_comb begin
      state_in = state_ff;
      ax_in    = ax_ff;
      cnt_in   = cnt_ff;
      cmd.ax   = ax_ff;
      cmd.step = cnt_ff;
      cmd.op   = OP_NONE;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               ax_in    = 1'b0;
               state_in = ST_VG;
            end
         end
         ST_VG:  begin cmd.op = OP_VG;  state_in = ST_DEC; end
         ST_DEC: begin cmd.op = OP_DEC; state_in = ST_EST; end
         ST_EST: begin cmd.op = OP_EST; state_in = ST_SW;  end
         ST_SW:  begin cmd.op = OP_SW;  state_in = ST_SWC; end
         ST_SWC: begin cmd.op = OP_SWC; state_in = ST_F1;  end
         ST_F1:  begin cmd.op = OP_F1;  state_in = ST_F1W; end
         ST_F1W: begin cmd.op = OP_F1W; state_in = ST_F2;  end
         ST_F2:  begin cmd.op = OP_F2;  state_in = ST_F2W; end
         ST_F2W: begin
            cmd.op = OP_F2W;
            if (!ax_ff) begin
               ax_in    = 1'b1;
               state_in = ST_VG;
            end else begin
               state_in = ST_CINIT;
            end
         end
         ST_CINIT: begin
            cmd.op   = OP_CINIT;
            cnt_in   = '0;
            state_in = ST_CROT;
         end
         ST_CROT: begin
            cmd.op = OP_CROT;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(CORDIC_STEPS - 1)) begin
               state_in = ST_ANG;
            end
         end
         ST_ANG:  begin cmd.op = OP_ANG;  state_in = ST_THW;  end
         ST_THW:  begin cmd.op = OP_THW;  state_in = ST_SPD;  end
         ST_SPD:  begin cmd.op = OP_SPD;  state_in = ST_SF;   end
         ST_SF:   begin cmd.op = OP_SF;   state_in = ST_SFW;  end
         ST_SFW:  begin cmd.op = OP_SFW;  state_in = ST_RPM;  end
         ST_RPM:  begin cmd.op = OP_RPM;  state_in = ST_RPMW; end
         ST_RPMW: begin cmd.op = OP_RPMW; state_in = ST_GAIN; end
         ST_GAIN: begin
            // result register must be free before the last step
            if (!stat.out_busy) begin
               cmd.op   = OP_GAIN;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `SMRO_ASSERT_NEXT(a_start, req_valid && !req_stall, state_ff == ST_VG, "accept did not start")
   `SMRO_ASSERT_NOW(a_busy_stall, state_ff != ST_IDLE, req_stall, "word taken while busy")
   `SMRO_ASSERT_NEXT(a_hold_gain, state_ff == ST_GAIN && stat.out_busy, state_ff == ST_GAIN,
      "result overwritten while held")

endmodule

[sv/smro_datapath.sv]
module smro_datapath
   import smro_pkg::*;
#(
   parameter int AVG_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output status_type   stat,
   input  req_word_type req_data,
   input  logic         csr_valid,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   localparam int PW = $clog2(AVG_DEPTH);
   localparam int SW = 17 + PW;

   // configuration
   logic [14:0] decay_ff, vgain_ff, slide_ff, mingain_ff, rpmscale_ff;
   logic [30:0] slidemax_ff;

   // observer state
   logic signed [31:0] est_ff [2];
   logic signed [31:0] sw_ff  [2];
   logic signed [31:0] e1_ff  [2];
   logic signed [31:0] e2_ff  [2];
   logic signed [31:0] volt_ff [2];
   logic signed [31:0] amp_ff  [2];
   logic signed [31:0] old_sw_ff, old_e1_ff;
   logic signed [40:0] acc_ff;
   logic signed [52:0] prod_ff;
   logic signed [35:0] cx_ff, cy_ff;
   logic signed [19:0] cz_ff;
   logic               zero_ff;
   logic signed [15:0] prev_ff, theta_ff;
   logic [PW-1:0]      pos_ff;
   logic [AVG_DEPTH-1:0] vld_ff;
   logic signed [SW-1:0] sum_ff;
   logic signed [31:0] spd_raw_ff, spd_old_ff, spd_flt_ff, rpm_ff;
   logic [15:0]        gain_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_data_ff;

   logic signed [35:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [52:0] product;
   logic signed [31:0] flt_old, flt_new;
   logic signed [41:0] est_sum;
   logic signed [31:0] est_new;
   logic signed [52:0] lim;
   logic signed [31:0] sw_new;
   logic signed [35:0] x0, y0, sx, sy;
   logic signed [15:0] theta_new, delta, ring_old;
   logic [15:0]        ring_rd;
   logic signed [SW-1:0] sum_new;
   logic signed [22:0] kq;
   logic [15:0]        k_cap, k_new;
   logic signed [15:0] pos_new;
   logic               ax;

   assign ax = cmd.ax;

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_VG: begin
            mul_a = 36'(volt_ff[ax]) - 36'(e1_ff[ax]) - 36'(sw_ff[ax]);
            mul_b = $signed({2'b0, vgain_ff});
         end
         OP_DEC: begin
            mul_a = 36'(est_ff[ax]);
            mul_b = $signed({2'b0, decay_ff});
         end
         OP_SW: begin
            mul_a = 36'(est_ff[ax]) - 36'(amp_ff[ax]);
            mul_b = $signed({2'b0, slide_ff});
         end
         OP_F1: begin
            mul_a = 36'(sw_ff[ax]) + 36'(old_sw_ff) - (36'(e1_ff[ax]) <<< 1);
            mul_b = $signed({1'b0, gain_ff});
         end
         OP_F2: begin
            mul_a = 36'(e1_ff[ax]) + 36'(old_e1_ff) - (36'(e2_ff[ax]) <<< 1);
            mul_b = $signed({1'b0, gain_ff});
         end
         OP_ANG: begin
            mul_a = 36'(cz_ff);
            mul_b = ANG_SCALE;
         end
         OP_SF: begin
            mul_a = 36'(spd_raw_ff) + 36'(spd_old_ff) - (36'(spd_flt_ff) <<< 1);
            mul_b = $signed({2'b0, mingain_ff});
         end
         OP_RPM: begin
            mul_a = 36'(spd_flt_ff);
            mul_b = $signed({2'b0, rpmscale_ff});
         end
         OP_RPMW: begin
            mul_a = 36'(spd_flt_ff);
            mul_b = GAIN_COEF;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      product = 53'(mul_a) * 53'(mul_b);
   end

   // filter write-back, current clamp, switching clamp
   always_comb begin
      unique case (cmd.op)
         OP_F1W:  flt_old = e1_ff[ax];
         OP_F2W:  flt_old = e2_ff[ax];
         default: flt_old = spd_flt_ff;
      endcase
      flt_new = sat32(64'(flt_old) + 64'(prod_ff >>> 15));

      est_sum = 42'(acc_ff) + 42'(prod_ff >>> 15);
      if (est_sum > 42'(EST_HI)) begin
         est_new = EST_HI;
      end else if (est_sum < 42'(EST_LO)) begin
         est_new = EST_LO;
      end else begin
         est_new = est_sum[31:0];
      end

      lim = $signed({22'b0, slidemax_ff});
      if (prod_ff > lim) begin
         sw_new = lim[31:0];
      end else if (prod_ff < -lim) begin
         sw_new = -lim[31:0];
      end else begin
         sw_new = prod_ff[31:0];
      end
   end

   // cordic operands
   always_comb begin
      x0 = 36'(e2_ff[1]);
      y0 = -36'(e2_ff[0]);
      sx = cx_ff >>> cmd.step;
      sy = cy_ff >>> cmd.step;
   end

   // angle step and running sum
   always_comb begin
      theta_new = prod_ff[30:15];
      delta     = theta_new - prev_ff;
      ring_old  = vld_ff[pos_ff] ? $signed(ring_rd) : 16'sd0;
      sum_new   = sum_ff - SW'(ring_old) + SW'(delta);
   end

   // gain update and compensated angle
   always_comb begin
      kq    = prod_ff[52:30];
      k_cap = (kq > 23'sd32767) ? 16'd32767 : kq[15:0];
      if (kq < $signed({8'b0, mingain_ff})) begin
         k_new = {1'b0, mingain_ff};
      end else begin
         k_new = k_cap;
      end
      pos_new = theta_ff + (rpm_ff[31] ? OFS_NEG : OFS_POS);
   end

   smro_ram #(
      .WIDTH(16),
      .DEPTH(AVG_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (cmd.op == OP_THW),
      .wr_addr(pos_ff),
      .wr_data(delta),
      .rd_addr(pos_ff),
      .rd_data(ring_rd)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff    <= '0;
         vgain_ff    <= '0;
         slide_ff    <= '0;
         slidemax_ff <= SLIDE_MAX_RST;
         mingain_ff  <= '0;
         rpmscale_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DECAY:    decay_ff    <= csr_data[14:0];
            CSR_VGAIN:    vgain_ff    <= csr_data[14:0];
            CSR_SLIDE:    slide_ff    <= csr_data[14:0];
            CSR_SLIDEMAX: slidemax_ff <= csr_data[30:0];
            CSR_MINGAIN:  mingain_ff  <= csr_data[14:0];
            CSR_RPM:      rpmscale_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // operand registers with no reset
   always_ff @(posedge clock) begin
      prod_ff <= product;
      unique case (cmd.op)
         OP_LOAD: begin
            volt_ff[0] <= req_data.volt_alpha;
            volt_ff[1] <= req_data.volt_beta;
            amp_ff[0]  <= req_data.amp_alpha;
            amp_ff[1]  <= req_data.amp_beta;
         end
         OP_DEC: acc_ff <= prod_ff[52:12];
         OP_CINIT: begin
            zero_ff <= (e2_ff[0] == 32'sd0) && (e2_ff[1] == 32'sd0);
            if (x0 < 0) begin
               cz_ff <= (y0 >= 0) ? PI_Q16 : -PI_Q16;
               cx_ff <= -x0;
               cy_ff <= -y0;
            end else begin
               cz_ff <= '0;
               cx_ff <= x0;
               cy_ff <= y0;
            end
         end
         OP_CROT: begin
            if (!zero_ff) begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + sy;
                  cy_ff <= cy_ff - sx;
                  cz_ff <= cz_ff + atan_q16(cmd.step);
               end else begin
                  cx_ff <= cx_ff - sy;
                  cy_ff <= cy_ff + sx;
                  cz_ff <= cz_ff - atan_q16(cmd.step);
               end
            end
         end
         OP_THW:  theta_ff <= theta_new;
         // rpm fits 32 bits after the shift by 25
         OP_RPMW: rpm_ff <= 32'(prod_ff >>> 25);
         OP_GAIN: begin
            rsp_data_ff.elec_position  <= pos_new;
            rsp_data_ff.elec_speed_rpm <= rpm_ff;
            rsp_data_ff.emf_alpha      <= e2_ff[0];
            rsp_data_ff.emf_beta       <= e2_ff[1];
         end
         default: ;
      endcase
   end

   // observer state
   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff[0] <= '0; est_ff[1] <= '0;
         sw_ff[0]  <= '0; sw_ff[1]  <= '0;
         e1_ff[0]  <= '0; e1_ff[1]  <= '0;
         e2_ff[0]  <= '0; e2_ff[1]  <= '0;
         old_sw_ff <= '0;
         old_e1_ff <= '0;
         prev_ff   <= '0;
         pos_ff    <= '0;
         vld_ff    <= '0;
         sum_ff    <= '0;
         spd_raw_ff <= '0;
         spd_old_ff <= '0;
         spd_flt_ff <= '0;
         gain_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result valid: set on the last step, cleared when taken
         if (cmd.op == OP_GAIN) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.op)
            OP_EST: est_ff[ax] <= est_new;
            OP_SWC: begin
               old_sw_ff <= sw_ff[ax];
               sw_ff[ax] <= sw_new;
            end
            OP_F1W: begin
               old_e1_ff <= e1_ff[ax];
               e1_ff[ax] <= flt_new;
            end
            OP_F2W: e2_ff[ax] <= flt_new;
            OP_THW: begin
               prev_ff <= theta_new;
               sum_ff  <= sum_new;
               vld_ff[pos_ff] <= 1'b1;
               pos_ff  <= (pos_ff == PW'(AVG_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
            end
            OP_SPD: begin
               spd_old_ff <= spd_raw_ff;
               spd_raw_ff <= sat32(64'(sum_ff) <<< 12);
            end
            OP_SFW: spd_flt_ff <= flt_new;
            OP_GAIN: gain_ff <= k_new;
            default: ;
         endcase
      end
   end

   assign stat.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

endmodule

[sv/sliding_mode_rotor_observer_unit.sv]
// channel | direction | handshake          | word
// req_    | in        | req_valid/req_stall | volt and current, alpha/beta, q16
// rsp_    | out       | rsp_valid/rsp_stall | angle, rpm, back-emf alpha/beta
// csr_    | in        | csr_valid/csr_ready | register index and data
// a word passes from acceptance to result through the single shared multiplier and the
// 16-step cordic unit, plus any wait on rsp_stall. a new word is taken only once the
// previous one has reached the result register, so words are never overlapped.
// reset is synchronous and clears all observer state and the delta ring valid bits.
module sliding_mode_rotor_observer_unit
   import smro_pkg::*;
#(
   parameter int AVG_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   cmd_type    cmd;
   status_type stat;

   // registers always take writes
   assign csr_ready = 1'b1;

   smro_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   smro_datapath #(
      .AVG_DEPTH(AVG_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

[verif/tb_top.sv]
module tb_top;
   import smro_pkg::*;

   localparam int RING_DEPTH = 16;
   localparam int LATENCY = 44;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 1030;

   localparam longint EST_MAX = 64'sd16383 * 64'sd65536;
   localparam longint EST_MIN = -64'sd16384 * 64'sd65536;
   localparam longint HALF_TURN_Q16 = 64'sd205887;
   localparam longint ANGLE_SCALE = 64'sd5215;
   localparam longint GAIN_SCALE = 64'sd25736;
   localparam longint OFFSET_FWD = 64'sd13007;
   localparam longint OFFSET_REV = 64'sd19761;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // observer settings held by the predictor
   longint decay_k, volt_k, slide_k, slide_lim, gain_floor, rpm_k;
   // observer state held by the predictor
   longint cur_est[2], sw_term[2], emf_stage1[2], emf_stage2[2];
   longint last_angle, step_sum, speed_unfilt, speed_smooth, filt_gain;
   longint step_ring[RING_DEPTH];
   int ring_wr;

   rsp_word_type expected_words[$];
   int fail_count = 0;
   int idle_pct_send = 0;
   int idle_pct_recv = 0;
   int hold_recv = 0;
   int quiet_cycles = 0;

   sliding_mode_rotor_observer_unit dut (.*);

   always #5 clock = ~clock;

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint wrap_angle(longint v);
      logic signed [15:0] w;
      w = v[15:0];
      return longint'(w);
   endfunction

   function automatic longint lowpass(longint x_new, longint x_old, longint y_old, longint k);
      return clip32(y_old + floor_shift((x_new + x_old - 2 * y_old) * k, 15));
   endfunction

   function automatic longint arc_table(int i);
      longint t[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2};
      return t[i];
   endfunction

   // vectoring cordic, atan2 in q16 radians
   function automatic longint vector_angle(longint y, longint x);
      longint z, t;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         if (y > 0) begin
            t = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z += arc_table(i);
         end else begin
            t = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z -= arc_table(i);
         end
         x = t;
      end
      return z;
   endfunction

   task automatic reset_observer();
      decay_k = 0; volt_k = 0; slide_k = 0; slide_lim = 536870912;
      gain_floor = 0; rpm_k = 0;
      for (int a = 0; a < 2; a++) begin
         cur_est[a] = 0; sw_term[a] = 0; emf_stage1[a] = 0; emf_stage2[a] = 0;
      end
      last_angle = 0; step_sum = 0; speed_unfilt = 0; speed_smooth = 0; filt_gain = 0;
      foreach (step_ring[i]) step_ring[i] = 0;
      ring_wr = 0;
   endtask

   task automatic apply_setting(logic [2:0] idx, logic [31:0] val);
      case (idx)
         CSR_DECAY:    decay_k = val[14:0];
         CSR_VGAIN:    volt_k = val[14:0];
         CSR_SLIDE:    slide_k = val[14:0];
         CSR_SLIDEMAX: slide_lim = val[30:0];
         CSR_MINGAIN:  gain_floor = val[14:0];
         CSR_RPM:      rpm_k = val[14:0];
         default: ;
      endcase
   endtask

   // advance the observer by one pwm period and return the estimate word
   function automatic rsp_word_type observe(req_word_type w);
      longint volt[2], amp[2], sw_prev[2], e1_prev[2];
      longint g, f, s, z, theta, delta, speed_prev, rpm, k;
      rsp_word_type r;
      volt[0] = w.volt_alpha; volt[1] = w.volt_beta;
      amp[0] = w.amp_alpha; amp[1] = w.amp_beta;
      for (int a = 0; a < 2; a++) begin
         g = floor_shift((volt[a] - emf_stage1[a] - sw_term[a]) * volt_k, 12);
         f = floor_shift(cur_est[a] * decay_k, 15);
         s = f + g;
         if (s > EST_MAX) s = EST_MAX;
         if (s < EST_MIN) s = EST_MIN;
         cur_est[a] = s;
      end
      for (int a = 0; a < 2; a++) begin
         sw_prev[a] = sw_term[a];
         z = (cur_est[a] - amp[a]) * slide_k;
         if (z > slide_lim) z = slide_lim;
         if (z < -slide_lim) z = -slide_lim;
         sw_term[a] = z;
      end
      for (int a = 0; a < 2; a++) begin
         e1_prev[a] = emf_stage1[a];
         emf_stage1[a] = lowpass(sw_term[a], sw_prev[a], emf_stage1[a], filt_gain);
         emf_stage2[a] = lowpass(emf_stage1[a], e1_prev[a], emf_stage2[a], filt_gain);
      end
      theta = wrap_angle(floor_shift(vector_angle(-emf_stage2[0], emf_stage2[1])
                                     * ANGLE_SCALE, 15));
      delta = wrap_angle(theta - last_angle);
      last_angle = theta;
      step_sum = step_sum - step_ring[ring_wr] + delta;
      step_ring[ring_wr] = delta;
      ring_wr = (ring_wr + 1) % RING_DEPTH;
      speed_prev = speed_unfilt;
      speed_unfilt = clip32(step_sum * 4096);
      speed_smooth = lowpass(speed_unfilt, speed_prev, speed_smooth, gain_floor);
      rpm = clip32(floor_shift(speed_smooth * rpm_k, 25));
      k = floor_shift(speed_smooth * GAIN_SCALE, 30);
      if (k > 32767) k = 32767;
      if (k < gain_floor) k = gain_floor;
      filt_gain = k;
      r.elec_position = wrap_angle(theta + (rpm >= 0 ? OFFSET_FWD : OFFSET_REV));
      r.elec_speed_rpm = rpm[31:0];
      r.emf_alpha = emf_stage2[0][31:0];
      r.emf_beta = emf_stage2[1][31:0];
      return r;
   endfunction

   // one register write, then valid is dropped before the task returns
   task automatic write_setting(logic [2:0] idx, logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_setting(idx, val);
      @(posedge clock);
   endtask

   // idle point: all results in, then latency for good measure
   task automatic drain();
      while (expected_words.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // offer one word, drop valid once it is taken
   task automatic send_word(req_word_type w);
      while (idle_pct_send != 0 && $urandom_range(99) < idle_pct_send) @(posedge clock);
      req_data <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_words.push_back(observe(w));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] edge_value();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] near_value();
      // mostly modest values so the current model stays in range
      if ($urandom_range(9) == 0) return edge_value();
      return 32'($signed($urandom_range(2 * 262144)) - 262144);
   endfunction

   // receiver: random stall per cycle, with a long hold-off while hold_recv counts down
   always @(posedge clock) begin
      if (hold_recv > 0) begin
         hold_recv <= hold_recv - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (idle_pct_recv != 0) && ($urandom_range(99) < idle_pct_recv);
      end
   end

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_data.elec_position !== e.elec_position) begin
               $error("elec_position expected %0d got %0d", e.elec_position,
                      rsp_data.elec_position);
               fail_count++;
            end
            if (rsp_data.elec_speed_rpm !== e.elec_speed_rpm) begin
               $error("elec_speed_rpm expected %0d got %0d", e.elec_speed_rpm,
                      rsp_data.elec_speed_rpm);
               fail_count++;
            end
            if (rsp_data.emf_alpha !== e.emf_alpha) begin
               $error("emf_alpha expected %0d got %0d", e.emf_alpha, rsp_data.emf_alpha);
               fail_count++;
            end
            if (rsp_data.emf_beta !== e.emf_beta) begin
               $error("emf_beta expected %0d got %0d", e.emf_beta, rsp_data.emf_beta);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   typedef struct {
      logic [31:0] va, vb, ia, ib;
      logic        fixed;
      logic [15:0] pos;
      logic [31:0] rpm;
   } stim_row_type;

   stim_row_type directed_rows[$];

   task automatic add_row(logic [31:0] va, logic [31:0] vb, logic [31:0] ia,
                          logic [31:0] ib, logic fixed, logic [15:0] pos, logic [31:0] rpm);
      stim_row_type r;
      r.va = va; r.vb = vb; r.ia = ia; r.ib = ib; r.fixed = fixed; r.pos = pos; r.rpm = rpm;
      directed_rows.push_back(r);
   endtask

   task automatic random_phase(int n, int ps, int pr);
      req_word_type w;
      idle_pct_send = ps;
      idle_pct_recv = pr;
      for (int i = 0; i < n; i++) begin
         w.volt_alpha = near_value();
         w.volt_beta = near_value();
         w.amp_alpha = near_value();
         w.amp_beta = near_value();
         send_word(w);
      end
   endtask

   task automatic random_settings();
      write_setting(CSR_DECAY, $urandom_range(1) ? $urandom_range(32767) : 32'h7FFF);
      write_setting(CSR_VGAIN, $urandom_range(4096));
      write_setting(CSR_SLIDE, $urandom_range(1) ? $urandom_range(8) : $urandom());
      write_setting(CSR_SLIDEMAX, $urandom_range(1) ? $urandom() : 32'h7FFF_FFFF);
      write_setting(CSR_MINGAIN, $urandom_range(2) == 0 ? 32'h7FFF : $urandom_range(8000));
      write_setting(CSR_RPM, $urandom());
   endtask

   initial begin
      req_word_type w;
      rsp_word_type e;
      reset_observer();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset with zero gains everything stays zero: angle is the forward offset
      add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
              16'd13007, 32'd0);
      add_row(32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 16'd13007, 32'd0);
      add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
              16'd13007, 32'd0);
      foreach (directed_rows[i]) begin
         w = {directed_rows[i].va, directed_rows[i].vb, directed_rows[i].ia,
              directed_rows[i].ib};
         send_word(w);
         e = expected_words[$];
         if (e.elec_position !== directed_rows[i].pos ||
             e.elec_speed_rpm !== directed_rows[i].rpm) begin
            $error("directed row %0d: predictor disagrees with table", i);
            fail_count++;
         end
      end
      drain();

      // extremes: full gains and limits, writes to unused indexes, saturating filters and current clamp
      write_setting(CSR_DECAY, 32'hFFFF_FFFF);
      write_setting(CSR_VGAIN, 32'h0000_7FFF);
      write_setting(CSR_SLIDE, 32'h7FFF);
      write_setting(CSR_SLIDEMAX, 32'hFFFF_FFFF);
      write_setting(CSR_MINGAIN, 32'h7FFF);
      write_setting(CSR_RPM, 32'h7FFF);
      write_setting(3'd6, 32'h1234);
      write_setting(3'd7, 32'h1234);
      for (int i = 0; i < 20; i++) begin
         w = {edge_value(), edge_value(), edge_value(), edge_value()};
         send_word(w);
      end
      drain();

      // receiver holds off while the sender keeps offering
      idle_pct_send = 0;
      hold_recv = 400;
      for (int i = 0; i < 6; i++) begin
         w = {near_value(), near_value(), near_value(), near_value()};
         send_word(w);
      end

      // random phases under varied settings and idling
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         random_settings();
         case (ph % 4)
            0: random_phase(N_RANDOM / 8, 0, 0);
            1: random_phase(N_RANDOM / 8, 74, 0);
            2: random_phase(N_RANDOM / 8, 0, 74);
            default: random_phase(N_RANDOM / 8, 7, 7);
         endcase
      end
      // zero settings again to revisit the low extremes
      drain();
      write_setting(CSR_DECAY, 0);
      write_setting(CSR_VGAIN, 0);
      write_setting(CSR_SLIDE, 0);
      write_setting(CSR_SLIDEMAX, 0);
      write_setting(CSR_MINGAIN, 0);
      write_setting(CSR_RPM, 0);
      random_phase(10, 7, 7);

      drain();
      if (fail_count == 0 && expected_words.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
